### rtl/eeip_pkg.sv
// ----------------------------------------------------------------------------
// eeip_pkg
// types and constants shared by the export entry index parser
// ----------------------------------------------------------------------------
package eeip_pkg;

  localparam int unsigned VersionWidth = 16;
  localparam int unsigned IndexWidth   = 32;
  localparam int unsigned CountWidth   = 3;
  localparam int unsigned SkipWidth    = 3;

  localparam logic [VersionWidth-1:0] VersionSkipMin = 16'd60;
  localparam logic [SkipWidth-1:0]    SkipBytes      = 3'd4;
  localparam logic [CountWidth-1:0]   LastCount      = 3'd4;

  localparam logic [7:0] SignBit  = 8'h80;
  localparam logic [7:0] MoreBit  = 8'h40;
  localparam logic [7:0] FirstMsk = 8'h3f;
  localparam logic [7:0] NextMsk  = 8'h7f;

  // field order within one export entry
  typedef enum logic [2:0] {
    StepClass    = 3'd0,
    StepSuper    = 3'd1,
    StepVerSkip  = 3'd2,
    StepName     = 3'd3,
    StepFixSkip  = 3'd4,
    StepSize     = 3'd5,
    StepOffset   = 3'd6
  } step_e;

  // running state of one compact index
  typedef struct packed {
    logic [CountWidth-1:0] count;
    logic [IndexWidth-1:0] mag;
    logic                  neg;
  } idx_state_t;

endpackage

### rtl/eeip_index_dec.sv
// ----------------------------------------------------------------------------
// eeip_index_dec
// one byte step of the compact index decoder
// ----------------------------------------------------------------------------
module eeip_index_dec
  import eeip_pkg::*;
(
  input  logic [7:0]            byte_i,
  input  idx_state_t            state_i,
  output idx_state_t            state_o,
  output logic                  done_o,
  output logic [IndexWidth-1:0] value_o
);

  logic [IndexWidth-1:0] bits7;
  logic [IndexWidth-1:0] mag;
  logic                  neg;

  assign bits7 = {{(IndexWidth-7){1'b0}}, byte_i[6:0] & NextMsk[6:0]};

  always_comb begin
    mag     = state_i.mag;
    neg     = state_i.neg;
    done_o  = 1'b0;
    state_o = state_i;
    if (state_i.count == '0) begin
      neg = |(byte_i & SignBit);
      mag = {{(IndexWidth-8){1'b0}}, byte_i & FirstMsk};
      if ((byte_i & MoreBit) != '0) begin
        state_o.count = 3'd1;
      end else begin
        done_o = 1'b1;
      end
    end else begin
      unique case (state_i.count)
        3'd1:    mag = state_i.mag | (bits7 << 6);
        3'd2:    mag = state_i.mag | (bits7 << 13);
        3'd3:    mag = state_i.mag | (bits7 << 20);
        default: mag = state_i.mag | (bits7 << 27);
      endcase
      // fifth byte always closes the index
      if ((byte_i & SignBit) == '0 || state_i.count >= LastCount) begin
        done_o = 1'b1;
      end else begin
        state_o.count = state_i.count + 3'd1;
      end
    end
    state_o.mag = mag;
    state_o.neg = neg;
    if (done_o) begin
      state_o = '0;
    end
  end

  assign value_o = neg ? (IndexWidth'(0) - mag) : mag;

endmodule

### rtl/export_entry_index_parser.sv
// ----------------------------------------------------------------------------
// export_entry_index_parser
// decodes export table entries from a byte stream of compact indices
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one raw export table byte per item. m_axis carries one
//   item per completed entry: class, name, size, offset and an offset flag.
//   cfg_we_i/cfg_data_i write package_version; at 60 or above an extra
//   4-byte field after the super index is skipped. write it only while idle.
// timing:
//   a byte is registered on acceptance and decoded in the following cycle;
//   an entry's result is registered when its last byte leaves the byte register.
//   one byte per cycle is sustained unless m_axis stalls; the byte register
//   and the result register form a two-stage pipe, the decoder between them.
// reset:
//   rst_ni clears the field sequencer, index accumulator, held fields and
//   package_version; parsing starts at a class index.
// stall:
//   while m_axis_tready is low and a result waits, the decode stage holds
//   and s_axis_tready drops once the byte register is also full.
// ----------------------------------------------------------------------------
module export_entry_index_parser
  import eeip_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [VersionWidth-1:0] cfg_data_i,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,   // [7:0] data_byte
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [31:0] class_ref, [63:32] name_ref, [95:64] object_size,
  // [127:96] object_offset, [128] offset_present, [135:129] zero
  output logic [135:0]            m_axis_tdata
);

  logic [VersionWidth-1:0] version_q;
  logic                    in_valid_q;
  logic [7:0]              in_byte_q;
  logic                    out_valid_q;
  logic [135:0]            out_data_q;

  step_e                   step_q, step_d;
  idx_state_t              idx_q, idx_d;
  logic [SkipWidth-1:0]    skip_q, skip_d;
  logic [IndexWidth-1:0]   class_q, class_d;
  logic [IndexWidth-1:0]   name_q, name_d;
  logic [IndexWidth-1:0]   size_q, size_d;

  idx_state_t              dec_in, dec_out;
  logic                    dec_done;
  logic [IndexWidth-1:0]   dec_value;
  logic                    advance;
  logic                    emit;
  logic [IndexWidth-1:0]   emit_offset;
  logic                    emit_present;
  logic                    is_index_step;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign is_index_step = (step_q != StepVerSkip) && (step_q != StepFixSkip);
  // an unused step code restarts with a fresh index
  assign dec_in = (step_q > StepOffset) ? '0 : idx_q;

  eeip_index_dec u_dec (
    .byte_i  (in_byte_q),
    .state_i (dec_in),
    .state_o (dec_out),
    .done_o  (dec_done),
    .value_o (dec_value)
  );

  always_comb begin
    step_d       = step_q;
    idx_d        = is_index_step ? dec_out : idx_q;
    skip_d       = skip_q;
    class_d      = class_q;
    name_d       = name_q;
    size_d       = size_q;
    emit         = 1'b0;
    emit_offset  = '0;
    emit_present = 1'b0;
    unique case (step_q)
      StepSuper: begin
        if (dec_done) begin
          if (version_q >= VersionSkipMin) begin
            step_d = StepVerSkip;
            skip_d = SkipBytes;
          end else begin
            step_d = StepName;
          end
        end
      end
      StepVerSkip, StepFixSkip: begin
        if (skip_q > 3'd1) begin
          skip_d = skip_q - 3'd1;
        end else begin
          skip_d = '0;
          step_d = (step_q == StepVerSkip) ? StepName : StepSize;
        end
      end
      StepName: begin
        if (dec_done) begin
          name_d = dec_value;
          step_d = StepFixSkip;
          skip_d = SkipBytes;
        end
      end
      StepSize: begin
        if (dec_done) begin
          size_d = dec_value;
          if (dec_value != '0 && !dec_value[IndexWidth-1]) begin
            step_d = StepOffset;
          end else begin
            emit   = 1'b1;
            step_d = StepClass;
          end
        end
      end
      StepOffset: begin
        if (dec_done) begin
          emit         = 1'b1;
          emit_offset  = dec_value;
          emit_present = 1'b1;
          step_d       = StepClass;
        end
      end
      default: begin
        // class index, also taken for unused step codes
        step_d = StepClass;
        if (dec_done) begin
          class_d = dec_value;
          step_d  = StepSuper;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q   <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= StepClass;
      idx_q       <= '0;
      skip_q      <= '0;
      class_q     <= '0;
      name_q      <= '0;
      size_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        version_q <= cfg_data_i;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= emit;
        step_q      <= step_d;
        idx_q       <= idx_d;
        skip_q      <= skip_d;
        class_q     <= class_d;
        name_q      <= name_d;
        size_q      <= size_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance && emit) begin
      out_data_q <= {7'd0, emit_present, emit_offset, size_d, name_q, class_q};
    end
  end

endmodule

### verif/tb_export_entry_index_parser.sv
// ----------------------------------------------------------------------------
// tb_export_entry_index_parser
// self-checking bench for the export entry compact index parser
// ----------------------------------------------------------------------------
// bytes of export entries, with some random noise, are queued per phase and
// fed by a bursty driver. A predictor follows every accepted byte and queues
// the decoded entries it expects. The monitor compares each result item with
// the oldest one. package_version is changed between phases while the block
// is idle. The receiver stalls on a pattern of its own and holds off once for
// a long stretch so that the byte pipe fills and back-pressures the sender.
// ----------------------------------------------------------------------------
module tb_export_entry_index_parser;
  import eeip_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned LongHoldOff  = 300;
  localparam int unsigned HoldOffAfter = 40;
  localparam int unsigned SettleCycles = 8;

  typedef enum logic [1:0] {
    RxFull,
    RxRandom,
    RxSparse,
    RxPeriodic
  } rx_mode_e;

  typedef struct packed {
    logic [IndexWidth-1:0] class_ref;
    logic [IndexWidth-1:0] name_ref;
    logic [IndexWidth-1:0] object_size;
    logic [IndexWidth-1:0] object_offset;
    logic                  offset_present;
  } export_entry_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_we_i      = 1'b0;
  logic [VersionWidth-1:0] cfg_data_i    = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [7:0]              s_axis_tdata  = '0;   // [7:0] data_byte
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // [31:0] class_ref, [63:32] name_ref, [95:64] object_size,
  // [127:96] object_offset, [128] offset_present, [135:129] zero
  logic [135:0]            m_axis_tdata;

  export_entry_index_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // stimulus and scoreboard
  logic [7:0]    pending_bytes [$];
  export_entry_t expected_entries [$];
  int unsigned   bytes_queued   = 0;
  int unsigned   bytes_accepted = 0;
  int unsigned   entries_seen   = 0;
  int unsigned   error_count    = 0;
  int unsigned   cycle_count    = 0;
  logic          byte_taken     = 1'b0;
  logic [VersionWidth-1:0] gen_version = '0;

  // predictor state
  logic [VersionWidth-1:0] pred_version   = '0;
  step_e                   pred_step      = StepClass;
  logic [CountWidth-1:0]   pred_count     = '0;
  logic [IndexWidth-1:0]   pred_mag       = '0;
  logic                    pred_neg       = 1'b0;
  logic [SkipWidth-1:0]    pred_skip      = '0;
  logic [IndexWidth-1:0]   pred_class     = '0;
  logic [IndexWidth-1:0]   pred_name      = '0;
  logic [IndexWidth-1:0]   pred_size      = '0;

  // driver and receiver pacing
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned mode_left  = 0;
  bit          hold_done  = 1'b0;
  rx_mode_e    rx_mode    = RxFull;

  // two entries at version 0: zero, negative zero, single byte maximum,
  // a five byte index whose last byte still flags more, size zero without
  // offset, and a positive size followed by a five byte offset
  logic [7:0] directed_bytes [26] = '{
    8'h00, 8'h80, 8'h3f, 8'h00, 8'hff, 8'h00, 8'hff, 8'h80,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'hc1, 8'h01,
    8'h55, 8'haa, 8'h00, 8'hff, 8'h01, 8'h40, 8'hff, 8'hff,
    8'hff, 8'h7f
  };

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // one byte into the compact index decoder; returns 1 when the index is done
  function automatic bit take_compact_byte(input logic [7:0] b,
                                           output logic [IndexWidth-1:0] value);
    bit done;
    done  = 1'b0;
    value = '0;
    if (pred_count == 0) begin
      pred_neg = b[7];
      pred_mag = IndexWidth'(b & FirstMsk);
      if ((b & MoreBit) != 0) begin
        pred_count = 3'd1;
      end else begin
        done = 1'b1;
      end
    end else begin
      pred_mag = pred_mag | (IndexWidth'(b & NextMsk) << (6 + 7 * (pred_count - 1)));
      // the fifth byte ends the index whatever its continue bit says
      if (!b[7] || pred_count >= LastCount) begin
        done = 1'b1;
      end else begin
        pred_count = pred_count + 3'd1;
      end
    end
    if (done) begin
      value      = pred_neg ? (32'd0 - pred_mag) : pred_mag;
      pred_count = '0;
      pred_mag   = '0;
      pred_neg   = 1'b0;
    end
    return done;
  endfunction

  task automatic parse_export_byte(input logic [7:0] b);
    logic [IndexWidth-1:0] v;
    export_entry_t         entry;
    case (pred_step)
      StepClass: begin
        if (take_compact_byte(b, v)) begin
          pred_class = v;
          pred_step  = StepSuper;
        end
      end
      StepSuper: begin
        if (take_compact_byte(b, v)) begin
          if (pred_version >= VersionSkipMin) begin
            pred_step = StepVerSkip;
            pred_skip = SkipBytes;
          end else begin
            pred_step = StepName;
          end
        end
      end
      StepVerSkip, StepFixSkip: begin
        if (pred_skip > 1) begin
          pred_skip = pred_skip - 3'd1;
        end else begin
          pred_skip = '0;
          pred_step = (pred_step == StepVerSkip) ? StepName : StepSize;
        end
      end
      StepName: begin
        if (take_compact_byte(b, v)) begin
          pred_name = v;
          pred_step = StepFixSkip;
          pred_skip = SkipBytes;
        end
      end
      StepSize: begin
        if (take_compact_byte(b, v)) begin
          pred_size = v;
          if (v != 0 && !v[31]) begin
            pred_step = StepOffset;
          end else begin
            entry = '{pred_class, pred_name, v, '0, 1'b0};
            expected_entries.push_back(entry);
            pred_step = StepClass;
          end
        end
      end
      StepOffset: begin
        if (take_compact_byte(b, v)) begin
          entry = '{pred_class, pred_name, pred_size, v, 1'b1};
          expected_entries.push_back(entry);
          pred_step = StepClass;
        end
      end
      default: begin
        // unused step code restarts at the class index
        pred_step  = StepClass;
        pred_count = '0;
        pred_mag   = '0;
        pred_neg   = 1'b0;
        if (take_compact_byte(b, v)) begin
          pred_class = v;
          pred_step  = StepSuper;
        end
      end
    endcase
  endtask

  // sender: bursts of random length separated by random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || byte_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        s_axis_tdata  <= pending_bytes.pop_front();
        s_axis_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: changing stall pattern plus one long hold-off
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && entries_seen >= HoldOffAfter) begin
      hold_done  = 1'b1;
      stall_left = LongHoldOff - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (rx_mode)
        RxFull:   m_axis_tready <= 1'b1;
        RxRandom: m_axis_tready <= 1'($urandom_range(0, 1));
        RxSparse: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:  m_axis_tready <= (mode_left % 5) < 2;
      endcase
    end
  end

  // monitor: sample at the rising edge, predict and compare
  always @(posedge clk_i) begin
    byte_taken = 1'b0;
    if (rst_ni) begin
      if (cfg_we_i) begin
        pred_version = cfg_data_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        entries_seen++;
        if (expected_entries.size() == 0) begin
          $error("result item with no entry expected: %h", m_axis_tdata);
          error_count++;
        end else begin
          automatic export_entry_t exp_entry = expected_entries.pop_front();
          if (m_axis_tdata[31:0] !== exp_entry.class_ref) begin
            $error("class_ref: expected %0d, actual %0d",
                   $signed(exp_entry.class_ref), $signed(m_axis_tdata[31:0]));
            error_count++;
          end
          if (m_axis_tdata[63:32] !== exp_entry.name_ref) begin
            $error("name_ref: expected %0d, actual %0d",
                   $signed(exp_entry.name_ref), $signed(m_axis_tdata[63:32]));
            error_count++;
          end
          if (m_axis_tdata[95:64] !== exp_entry.object_size) begin
            $error("object_size: expected %0d, actual %0d",
                   $signed(exp_entry.object_size), $signed(m_axis_tdata[95:64]));
            error_count++;
          end
          if (m_axis_tdata[127:96] !== exp_entry.object_offset) begin
            $error("object_offset: expected %0d, actual %0d",
                   $signed(exp_entry.object_offset), $signed(m_axis_tdata[127:96]));
            error_count++;
          end
          if (m_axis_tdata[128] !== exp_entry.offset_present) begin
            $error("offset_present: expected %0d, actual %0d",
                   exp_entry.offset_present, m_axis_tdata[128]);
            error_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        byte_taken = 1'b1;
        bytes_accepted++;
        parse_export_byte(s_axis_tdata);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  // random compact index of 1 to 5 bytes; value is what it decodes to
  task automatic push_index(output logic [IndexWidth-1:0] value);
    int unsigned           r;
    int unsigned           nbytes;
    logic                  neg;
    logic [6:0]            chunk;
    logic                  more;
    logic [IndexWidth-1:0] mag;
    r      = $urandom_range(0, 9);
    nbytes = (r < 4) ? 1 : (r < 6) ? 2 : (r < 7) ? 3 : (r < 8) ? 4 : 5;
    neg    = 1'($urandom_range(0, 1));
    chunk  = 7'($urandom);
    push_byte({neg, nbytes > 1, chunk[5:0]});
    mag = IndexWidth'(chunk[5:0]);
    for (int i = 1; i < nbytes; i++) begin
      chunk = 7'($urandom);
      more  = (i < nbytes - 1) ? 1'b1 : (i == 4) ? 1'($urandom_range(0, 1)) : 1'b0;
      push_byte({more, chunk});
      mag = mag | (IndexWidth'(chunk) << (6 + 7 * (i - 1)));
    end
    value = neg ? (32'd0 - mag) : mag;
  endtask

  task automatic push_entry();
    logic [IndexWidth-1:0] v;
    logic [IndexWidth-1:0] size;
    push_index(v);
    push_index(v);
    if (gen_version >= VersionSkipMin) begin
      repeat (SkipBytes) push_byte(8'($urandom));
    end
    push_index(v);
    repeat (SkipBytes) push_byte(8'($urandom));
    push_index(size);
    if (size != 0 && !size[31]) begin
      push_index(v);
    end
  endtask

  // mostly well-formed entries, about one in ten a run of raw noise
  task automatic fill_phase(input int unsigned target);
    int unsigned start;
    start = bytes_queued;
    while (bytes_queued - start < target) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5)) push_byte(8'($urandom));
      end else begin
        push_entry();
      end
    end
  endtask

  task automatic wait_idle();
    while (bytes_accepted != bytes_queued || expected_entries.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_version(input logic [VersionWidth-1:0] v);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    gen_version = v;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_version(16'd0);
    foreach (directed_bytes[i]) push_byte(directed_bytes[i]);
    fill_phase(180);
    wait_idle();

    // just below and at the version threshold, then the maximum and random versions
    write_version(VersionSkipMin - 1);
    fill_phase(230);
    wait_idle();
    write_version(VersionSkipMin);
    fill_phase(230);
    wait_idle();
    write_version(16'hffff);
    fill_phase(250);
    wait_idle();
    write_version(16'($urandom));
    fill_phase(250);
    wait_idle();
    write_version(16'($urandom_range(0, 59)));
    fill_phase(240);
    wait_idle();

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
